// ===== hw/rtl/sdta_pkg.sv =====
// shared types, constants and digit step function for the signed decimal to ascii block
`default_nettype none
package sdta_pkg;

   localparam int SDTA_QUEUE_DEPTH = 2;

   localparam logic [13:0] SDTA_MAX_MAG = 14'd9999;
   localparam logic [6:0]  SDTA_ASCII_MINUS = 7'd45;
   localparam logic [6:0]  SDTA_ASCII_PLUS  = 7'd43;
   localparam logic [6:0]  SDTA_ASCII_ZERO  = 7'd48;

   // multiples of each decimal place weight, row = place (ones first), column = multiplier
   localparam logic [13:0] SDTA_MULT [4][10] = '{
      '{14'd0, 14'd1,    14'd2,    14'd3,    14'd4,
        14'd5, 14'd6,    14'd7,    14'd8,    14'd9},
      '{14'd0, 14'd10,   14'd20,   14'd30,   14'd40,
        14'd50, 14'd60,  14'd70,   14'd80,   14'd90},
      '{14'd0, 14'd100,  14'd200,  14'd300,  14'd400,
        14'd500, 14'd600, 14'd700, 14'd800,  14'd900},
      '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
        14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000}
   };

   typedef struct packed {
      logic signed [14:0] value;
      logic [2:0]         digit_count;
      logic               show_sign;
   } sdta_req_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic       last_char;
   } sdta_rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic        negative;
      logic        show_sign;
      logic [1:0]  lead_place;
      logic [13:0] mag;
   } sdta_job_type;

   typedef struct packed {
      logic [3:0]  digit;
      logic [13:0] rem;
   } sdta_step_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_SIGN  = 3'b010,
      PH_DIGIT = 3'b100
   } sdta_phase_type;

   // one decimal digit of rem at the given place, rem known below ten times the weight
   function automatic sdta_step_type sdta_digit_step(input logic [13:0] rem,
                                                     input logic [1:0] place);
      sdta_step_type res;
      res.digit = 4'd0;
      res.rem   = rem;
      for (int k = 1; k < 10; k++) begin
         if (rem >= SDTA_MULT[place][k]) begin
            res.digit = 4'(k);
            res.rem   = rem - SDTA_MULT[place][k];
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/signed_decimal_to_ascii_top.sv =====
// top level of the signed decimal to ascii formatter
//
// usage
//   req channel: one item per number (signed value, digit count, show-sign flag),
//   accepted when req_valid and req_ready are both high
//   rsp channel: one item per ascii character, optional '+' or '-' first, then the
//   low 1 to 4 decimal digits, most significant first; last_char marks the ones digit
//   magnitudes above 9999 come out as 9999; digit counts above 4 act as 4
// timing
//   the front classifies an item in the accept cycle and writes it into a small queue,
//   so req_ready only drops while that queue is full
//   the back sequencer handles the sign (if shown) and then one decimal place per cycle
//   while no shown character waits on the output (always four places, places not shown
//   are just stepped over); from an idle block an accepted item passes the queue, the
//   sequencer load and the output register, after stepping over any hidden places ahead
//   of it, before its first character is valid; the next number is loaded in the same
//   cycle as the ones place of the last, so numbers follow with no idle step between them
// reset and stall
//   reset empties the queue, idles the sequencer and drops rsp_valid
//   when rsp_ready is low the output register holds its character and the sequencer
//   waits at its next shown character; the queue keeps taking items until it fills
`default_nettype none
module signed_decimal_to_ascii_top #(
   parameter int QUEUE_DEPTH = sdta_pkg::SDTA_QUEUE_DEPTH
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  sdta_pkg::sdta_req_type  req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output sdta_pkg::sdta_rsp_type  rsp_data
);
   import sdta_pkg::*;

   // classified item from the front
   sdta_job_type front_job;
   // queue head seen by the back
   sdta_job_type head_job;
   logic         head_valid;
   logic         head_pop;
   logic         queue_full;

   sdta_front u_front (
      .req (req_data),
      .job (front_job)
   );

   // queue decouples accept from character sequencing
   sdta_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_job   (front_job),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   assign req_ready = !queue_full;

   // one place per cycle unless a shown character waits on the output, output register toward the rsp channel
   sdta_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (head_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/sdta_front.sv =====
// front end: magnitude, saturation and digit count classification of an incoming item
`default_nettype none
module sdta_front (
   input  sdta_pkg::sdta_req_type req,
   output sdta_pkg::sdta_job_type job
);
   import sdta_pkg::*;

   logic        negative;
   logic [14:0] abs_val;

   always_comb begin
      negative = req.value[14];
      abs_val  = negative ? 15'(~req.value + 15'sd1) : 15'(req.value);

      job.negative  = negative;
      job.show_sign = req.show_sign;
      job.mag       = (abs_val > 15'(SDTA_MAX_MAG)) ? SDTA_MAX_MAG : abs_val[13:0];
      priority if (req.digit_count >= 3'd4) begin
         job.lead_place = 2'd3;
      end else if (req.digit_count == 3'd3) begin
         job.lead_place = 2'd2;
      end else if (req.digit_count == 3'd2) begin
         job.lead_place = 2'd1;
      end else begin
         job.lead_place = 2'd0;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sdta_queue.sv =====
// short job queue between front and back
`default_nettype none
module sdta_queue #(
   parameter int DEPTH = sdta_pkg::SDTA_QUEUE_DEPTH
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  sdta_pkg::sdta_job_type  push_job,
   output logic                    full,
   input  wire                     pop,
   output logic                    head_valid,
   output sdta_pkg::sdta_job_type  head_job
);
   import sdta_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sdta_job_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full       = (count_ff == CNT_W'(DEPTH));
      head_valid = (count_ff != '0);
      head_job   = slot_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sdta_back.sv =====
// back end: sign and digit sequencer with registered character output
`default_nettype none
module sdta_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     job_valid,
   input  sdta_pkg::sdta_job_type  job,
   output logic                    job_pop,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output sdta_pkg::sdta_rsp_type  rsp_data
);
   import sdta_pkg::*;

   sdta_phase_type phase_ff, phase_in;
   logic [1:0]     place_ff, place_in;
   logic [1:0]     lead_ff, lead_in;
   logic [13:0]    rem_ff, rem_in;
   logic           neg_ff, neg_in;
   logic           rsp_valid_ff, rsp_valid_in;
   sdta_rsp_type   rsp_data_ff, rsp_data_in;

   sdta_step_type  step;
   logic           out_free;
   logic           emit_digit;
   logic           load;

   always_comb begin
      step       = sdta_digit_step(rem_ff, place_ff);
      out_free   = !rsp_valid_ff || rsp_ready;
      emit_digit = (place_ff <= lead_ff);

      phase_in     = phase_ff;
      place_in     = place_ff;
      lead_in      = lead_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      load         = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            load = job_valid;
         end
         PH_SIGN: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.char_code = neg_ff ? SDTA_ASCII_MINUS : SDTA_ASCII_PLUS;
               rsp_data_in.last_char = 1'b0;
               phase_in              = PH_DIGIT;
            end
         end
         PH_DIGIT: begin
            if (!emit_digit || out_free) begin
               if (emit_digit) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.char_code = SDTA_ASCII_ZERO + 7'(step.digit);
                  rsp_data_in.last_char = (place_ff == 2'd0);
               end
               rem_in = step.rem;
               if (place_ff == 2'd0) begin
                  phase_in = PH_IDLE;
                  load     = job_valid;
               end else begin
                  place_in = place_ff - 2'd1;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (load) begin
         neg_in   = job.negative;
         lead_in  = job.lead_place;
         rem_in   = job.mag;
         place_in = 2'd3;
         phase_in = job.show_sign ? PH_SIGN : PH_DIGIT;
      end

      job_pop   = load;
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      place_ff    <= place_in;
      lead_ff     <= lead_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire
